/* sv/crs_pkg.sv */
// Shared types, constants and helpers for the corner response stream.
package crs_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = 10;
   localparam int ROW_W = 11;
   localparam int LW_W = 11;
   localparam int PIX_W = 8;
   localparam int GRAD_W = 11;
   localparam int NLANES = 3;
   localparam int GLINES = 6;
   localparam int GWIN = 7;
   localparam int FIRST_OUT = 8;
   localparam int MIN_WIDTH = 9;
   localparam int PROD_W = 21;
   localparam int VB_W = 24;
   localparam int HB_W = 27;
   localparam int TR_W = 28;
   localparam int MUL_W = 29;
   localparam int MP_W = 58;
   localparam int ACC_W = 72;
   localparam int FRAC_W = 16;
   localparam int T2_W = 54;
   localparam int T2_SPLIT = 28;
   localparam int DET_W = 55;
   localparam int DIFF_W = 57;
   localparam int RSP_W = 48;
   localparam int WGT_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_FACTOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_TAP1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_TAP2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_TAP3 = 3'd6;

   localparam logic [LW_W-1:0] LW_RESET = 11'd640;
   localparam logic [WGT_W-1:0] K_RESET = 16'd2621;
   localparam logic [WGT_W-1:0] G0_RESET = 16'd13037;
   localparam logic [WGT_W-1:0] G1_RESET = 16'd11506;
   localparam logic [WGT_W-1:0] G2_RESET = 16'd7910;
   localparam logic [WGT_W-1:0] G3_RESET = 16'd4232;

   localparam logic [1:0] LANE_XX = 2'd0;
   localparam logic [1:0] LANE_YY = 2'd1;
   localparam logic [1:0] LANE_XY = 2'd2;
   localparam logic [2:0] TAP_LAST = 3'(GWIN - 1);
   localparam logic [2:0] LINE_TOP = 3'(GLINES - 1);

   typedef enum logic [2:0] {
      A_NONE, A_GX, A_GY, A_WEIGHT, A_RES, A_TR, A_K
   } a_sel_type;

   typedef enum logic [3:0] {
      B_NONE, B_GX, B_GY, B_LINE, B_CUR, B_HWIN, B_RES, B_TR, B_T2LO, B_T2HI
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_CUR, WB_HWIN, WB_RES, WB_T2, WB_DET, WB_KT
   } wb_op_type;

   typedef struct packed {
      a_sel_type a_sel;
      logic [1:0] a_lane;
      b_sel_type b_sel;
      logic [1:0] b_lane;
      logic [2:0] tap;
      acc_op_type acc_op;
      wb_op_type wb_op;
      logic accept;
      logic win_shift;
      logic commit;
      logic out_load;
      logic clear_we;
      logic [COL_W-1:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic [LW_W-1:0] line_width;
      logic [WGT_W-1:0] k_factor;
      logic signed [RSP_W-1:0] corner_threshold;
      logic [3:0][WGT_W-1:0] gauss_w;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix1;
      logic [PIX_W-1:0] pix0;
      logic [NLANES-1:0][GLINES-1:0][PROD_W-1:0] blur;
   } mem_row_type;

   function automatic logic [1:0] tap_dist(input logic [2:0] tap);
      logic [1:0] d;
      unique case (tap)
         3'd0: d = 2'd3;
         3'd1: d = 2'd2;
         3'd2: d = 2'd1;
         3'd3: d = 2'd0;
         3'd4: d = 2'd1;
         3'd5: d = 2'd2;
         default: d = 2'd3;
      endcase
      return d;
   endfunction

endpackage

/* sv/crs_ctrl.sv */
// Sequencer that steps the shared multiplier through one pixel's work.
module crs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  crs_pkg::sts_type sts,
   output crs_pkg::cmd_type cmd
);
   import crs_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WIN, S_PROD, S_VBLUR, S_HBLUR, S_FIN, S_DRAIN, S_DIFF, S_EMIT
   } state_type;

   localparam logic [2:0] PROD_LAST = 3'd2;
   localparam logic [2:0] FIN_TR = 3'd0;
   localparam logic [2:0] FIN_AB = 3'd2;
   localparam logic [2:0] FIN_CC = 3'd3;
   localparam logic [2:0] FIN_KLO = 3'd4;
   localparam logic [2:0] FIN_KHI = 3'd5;
   localparam logic [2:0] DRAIN_LAST = 3'd1;

   state_type state_ff;
   logic [1:0] lane_ff;
   logic [2:0] tap_ff;
   logic [COL_W-1:0] clr_ff;
   logic stall_ff;

   assign req_stall = stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         lane_ff <= LANE_XX;
         tap_ff <= '0;
         clr_ff <= '0;
         stall_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_WIN;
                  stall_ff <= 1'b1;
               end
            end
            S_WIN: begin
               state_ff <= S_PROD;
               tap_ff <= '0;
            end
            S_PROD: begin
               if (tap_ff == PROD_LAST) begin
                  state_ff <= S_VBLUR;
                  tap_ff <= '0;
                  lane_ff <= LANE_XX;
               end else begin
                  tap_ff <= tap_ff + 1'b1;
               end
            end
            S_VBLUR, S_HBLUR: begin
               if (tap_ff == TAP_LAST) begin
                  tap_ff <= '0;
                  if (lane_ff == LANE_XY) begin
                     lane_ff <= LANE_XX;
                     state_ff <= (state_ff == S_VBLUR) ? S_HBLUR : S_FIN;
                  end else begin
                     lane_ff <= lane_ff + 1'b1;
                  end
               end else begin
                  tap_ff <= tap_ff + 1'b1;
               end
            end
            S_FIN: begin
               if (tap_ff == FIN_KHI) begin
                  state_ff <= S_DRAIN;
                  tap_ff <= '0;
               end else begin
                  tap_ff <= tap_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               if (tap_ff == DRAIN_LAST) begin
                  state_ff <= S_DIFF;
               end else begin
                  tap_ff <= tap_ff + 1'b1;
               end
            end
            S_DIFF: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!sts.emit || sts.out_free) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.clr_addr = clr_ff;
      cmd.tap = tap_ff;
      unique case (state_ff)
         S_CLEAR: cmd.clear_we = 1'b1;
         S_IDLE: cmd.accept = req_valid;
         S_WIN: cmd.win_shift = 1'b1;
         S_PROD: begin
            cmd.acc_op = ACC_LOAD;
            cmd.wb_op = WB_CUR;
            cmd.b_lane = tap_ff[1:0];
            unique case (tap_ff[1:0])
               LANE_XX: begin
                  cmd.a_sel = A_GX;
                  cmd.b_sel = B_GX;
               end
               LANE_YY: begin
                  cmd.a_sel = A_GY;
                  cmd.b_sel = B_GY;
               end
               default: begin
                  cmd.a_sel = A_GX;
                  cmd.b_sel = B_GY;
               end
            endcase
         end
         S_VBLUR: begin
            cmd.a_sel = A_WEIGHT;
            cmd.b_lane = lane_ff;
            cmd.b_sel = (tap_ff == TAP_LAST) ? B_CUR : B_LINE;
            cmd.acc_op = (tap_ff == '0) ? ACC_LOAD : ACC_ADD;
            cmd.wb_op = (tap_ff == TAP_LAST) ? WB_HWIN : WB_NONE;
         end
         S_HBLUR: begin
            cmd.a_sel = A_WEIGHT;
            cmd.b_lane = lane_ff;
            cmd.b_sel = B_HWIN;
            cmd.acc_op = (tap_ff == '0) ? ACC_LOAD : ACC_ADD;
            cmd.wb_op = (tap_ff == TAP_LAST) ? WB_RES : WB_NONE;
         end
         S_FIN: begin
            unique case (tap_ff)
               FIN_TR: begin
                  cmd.a_sel = A_TR;
                  cmd.b_sel = B_TR;
                  cmd.acc_op = ACC_LOAD;
                  cmd.wb_op = WB_T2;
               end
               FIN_AB: begin
                  cmd.a_sel = A_RES;
                  cmd.a_lane = LANE_XX;
                  cmd.b_sel = B_RES;
                  cmd.b_lane = LANE_YY;
                  cmd.acc_op = ACC_LOAD;
               end
               FIN_CC: begin
                  cmd.a_sel = A_RES;
                  cmd.a_lane = LANE_XY;
                  cmd.b_sel = B_RES;
                  cmd.b_lane = LANE_XY;
                  cmd.acc_op = ACC_SUB;
                  cmd.wb_op = WB_DET;
               end
               FIN_KLO: begin
                  cmd.a_sel = A_K;
                  cmd.b_sel = B_T2LO;
                  cmd.acc_op = ACC_LOAD;
               end
               FIN_KHI: begin
                  cmd.a_sel = A_K;
                  cmd.b_sel = B_T2HI;
                  cmd.acc_op = ACC_ADD_HI;
                  cmd.wb_op = WB_KT;
               end
               default: cmd.acc_op = ACC_NOP;
            endcase
         end
         S_DRAIN: cmd.acc_op = ACC_NOP;
         S_DIFF: cmd.commit = 1'b1;
         S_EMIT: cmd.out_load = sts.emit && sts.out_free;
         default: cmd.acc_op = ACC_NOP;
      endcase
   end

endmodule

/* sv/crs_datapath.sv */
// Line store, windows, shared multiply-accumulate unit and result register.
module crs_datapath (
   input  logic clock,
   input  logic reset,
   input  crs_pkg::cmd_type cmd,
   output crs_pkg::sts_type sts,
   input  crs_pkg::cfg_type cfg,
   input  logic [7:0] req_pixel,
   input  logic req_line_end,
   input  logic req_frame_end,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic signed [47:0] rsp_response,
   output logic rsp_is_corner,
   output logic rsp_row_done,
   output logic rsp_frame_done
);
   import crs_pkg::*;

   typedef struct packed {
      acc_op_type acc_op;
      wb_op_type wb_op;
      logic [1:0] lane;
   } stage_type;

   mem_row_type mem_ram [MAX_WIDTH];
   mem_row_type rd_ff;
   mem_row_type wr_row;
   logic mem_we;
   logic [COL_W-1:0] mem_wa;
   mem_row_type mem_wd;

   logic [PIX_W-1:0] pix_ff;
   logic le_ff, fe_ff;
   logic [2:0][2:0][PIX_W-1:0] pwin_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   logic signed [GRAD_W-1:0] gx, gy;
   logic [GRAD_W-1:0] gx_r, gx_l, gy_b, gy_t;
   logic signed [TR_W-1:0] tr;
   logic [2:0] line_idx;
   logic signed [MUL_W-1:0] opa, opb;
   logic signed [MP_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] rnd;
   stage_type st1_ff, st2_ff;

   logic signed [PROD_W-1:0] cur_ff [NLANES];
   logic signed [VB_W-1:0] hwin_ff [NLANES][GWIN];
   logic signed [HB_W-1:0] res_ff [NLANES];
   logic [T2_W-1:0] t2_ff;
   logic signed [DET_W-1:0] det_ff;
   logic [T2_W-1:0] kt_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic emit_ff, lover_ff, fedone_ff;

   logic [LW_W-1:0] lw_c;
   logic line_over;
   logic signed [RSP_W-1:0] sat;

   logic rsp_valid_ff, corner_ff, row_done_ff, frame_done_ff;
   logic signed [RSP_W-1:0] response_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_response = response_ff;
   assign rsp_is_corner = corner_ff;
   assign rsp_row_done = row_done_ff;
   assign rsp_frame_done = frame_done_ff;
   assign sts.emit = emit_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_row = '0;
      wr_row.pix0 = pix_ff;
      wr_row.pix1 = rd_ff.pix0;
      for (int j = 0; j < NLANES; j++) begin
         wr_row.blur[j][0] = cur_ff[j];
         for (int k = 1; k < GLINES; k++) begin
            wr_row.blur[j][k] = rd_ff.blur[j][k-1];
         end
      end
   end

   assign mem_we = cmd.clear_we || cmd.commit;
   assign mem_wa = cmd.clear_we ? cmd.clr_addr : col_ff;
   assign mem_wd = cmd.clear_we ? mem_row_type'('0) : wr_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_wa] <= mem_wd;
      end
      rd_ff <= mem_ram[col_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= req_pixel;
         le_ff <= req_line_end;
         fe_ff <= req_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwin_ff <= '0;
      end else if (cmd.win_shift) begin
         for (int r = 0; r < 3; r++) begin
            pwin_ff[r][0] <= pwin_ff[r][1];
            pwin_ff[r][1] <= pwin_ff[r][2];
         end
         pwin_ff[0][2] <= rd_ff.pix1;
         pwin_ff[1][2] <= rd_ff.pix0;
         pwin_ff[2][2] <= pix_ff;
      end
   end

   always_comb begin
      gx_r = {3'b0, pwin_ff[0][2]} + {2'b0, pwin_ff[1][2], 1'b0} + {3'b0, pwin_ff[2][2]};
      gx_l = {3'b0, pwin_ff[0][0]} + {2'b0, pwin_ff[1][0], 1'b0} + {3'b0, pwin_ff[2][0]};
      gy_b = {3'b0, pwin_ff[2][0]} + {2'b0, pwin_ff[2][1], 1'b0} + {3'b0, pwin_ff[2][2]};
      gy_t = {3'b0, pwin_ff[0][0]} + {2'b0, pwin_ff[0][1], 1'b0} + {3'b0, pwin_ff[0][2]};
      gx = $signed(gx_r - gx_l);
      gy = $signed(gy_b - gy_t);
      tr = TR_W'(res_ff[LANE_XX]) + TR_W'(res_ff[LANE_YY]);
      line_idx = LINE_TOP - cmd.tap;
   end

   always_comb begin
      unique case (cmd.a_sel)
         A_GX: opa = MUL_W'(gx);
         A_GY: opa = MUL_W'(gy);
         A_WEIGHT: opa = MUL_W'({1'b0, cfg.gauss_w[tap_dist(cmd.tap)]});
         A_RES: opa = MUL_W'(res_ff[cmd.a_lane]);
         A_TR: opa = MUL_W'(tr);
         A_K: opa = MUL_W'({1'b0, cfg.k_factor});
         default: opa = '0;
      endcase
      unique case (cmd.b_sel)
         B_GX: opb = MUL_W'(gx);
         B_GY: opb = MUL_W'(gy);
         B_LINE: opb = MUL_W'($signed(rd_ff.blur[cmd.b_lane][line_idx]));
         B_CUR: opb = MUL_W'(cur_ff[cmd.b_lane]);
         B_HWIN: opb = MUL_W'(hwin_ff[cmd.b_lane][cmd.tap]);
         B_RES: opb = MUL_W'(res_ff[cmd.b_lane]);
         B_TR: opb = MUL_W'(tr);
         B_T2LO: opb = MUL_W'({1'b0, t2_ff[T2_SPLIT-1:0]});
         B_T2HI: opb = MUL_W'({1'b0, t2_ff[T2_W-1:T2_SPLIT]});
         default: opb = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= '{acc_op: ACC_NOP, wb_op: WB_NONE, lane: LANE_XX};
         st2_ff <= '{acc_op: ACC_NOP, wb_op: WB_NONE, lane: LANE_XX};
      end else begin
         st1_ff <= '{acc_op: cmd.acc_op, wb_op: cmd.wb_op, lane: cmd.b_lane};
         st2_ff <= st1_ff;
      end
   end

   always_ff @(posedge clock) begin
      unique case (st1_ff.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff);
         ACC_ADD: acc_ff <= acc_ff + ACC_W'(prod_ff);
         ACC_SUB: acc_ff <= acc_ff - ACC_W'(prod_ff);
         ACC_ADD_HI: acc_ff <= acc_ff + (ACC_W'(prod_ff) <<< T2_SPLIT);
         default: acc_ff <= acc_ff;
      endcase
   end

   assign rnd = (acc_ff + (ACC_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;

   always_ff @(posedge clock) begin
      unique case (st2_ff.wb_op)
         WB_CUR: cur_ff[st2_ff.lane] <= acc_ff[PROD_W-1:0];
         WB_RES: res_ff[st2_ff.lane] <= rnd[HB_W-1:0];
         WB_T2: t2_ff <= acc_ff[T2_W-1:0];
         WB_DET: det_ff <= acc_ff[DET_W-1:0];
         WB_KT: kt_ff <= rnd[T2_W-1:0];
         default: t2_ff <= t2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NLANES; j++) begin
            for (int i = 0; i < GWIN; i++) begin
               hwin_ff[j][i] <= '0;
            end
         end
      end else if (st2_ff.wb_op == WB_HWIN) begin
         for (int i = 0; i < GWIN - 1; i++) begin
            hwin_ff[st2_ff.lane][i] <= hwin_ff[st2_ff.lane][i+1];
         end
         hwin_ff[st2_ff.lane][GWIN-1] <= rnd[VB_W-1:0];
      end
   end

   always_comb begin
      if (cfg.line_width < LW_W'(MIN_WIDTH)) begin
         lw_c = LW_W'(MIN_WIDTH);
      end else if (cfg.line_width > LW_W'(MAX_WIDTH)) begin
         lw_c = LW_W'(MAX_WIDTH);
      end else begin
         lw_c = cfg.line_width;
      end
      line_over = le_ff || ({1'b0, col_ff} >= (lw_c - 1'b1));
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         diff_ff <= DIFF_W'(det_ff) - DIFF_W'($signed({1'b0, kt_ff}));
         lover_ff <= line_over;
         fedone_ff <= fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         emit_ff <= 1'b0;
      end else if (cmd.commit) begin
         emit_ff <= (row_ff >= ROW_W'(FIRST_OUT)) && (col_ff >= COL_W'(FIRST_OUT));
         if (fe_ff) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (line_over) begin
            col_ff <= '0;
            if (!(&row_ff)) begin
               row_ff <= row_ff + 1'b1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if ((&diff_ff[DIFF_W-1:RSP_W-1]) || !(|diff_ff[DIFF_W-1:RSP_W-1])) begin
         sat = diff_ff[RSP_W-1:0];
      end else if (diff_ff[DIFF_W-1]) begin
         sat = {1'b1, {(RSP_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(RSP_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         response_ff <= sat;
         corner_ff <= sat > cfg.corner_threshold;
         row_done_ff <= lover_ff;
         frame_done_ff <= fedone_ff;
      end
   end

endmodule

/* sv/corner_response_stream.sv */
// Top level of the corner response stream: configuration registers and core.
//
// Pixels enter in raster order on the req_ channel, one beat per pixel with
// line_end and frame_end marks. Each interior pixel with a full 9x9 support
// gives one rsp_ beat: the saturated 48-bit response, the corner flag and the
// row and frame end marks; border pixels give no beat.
// Each pixel is worked through in full, with req_stall high, before the next
// pixel can be accepted. The pace is set by the single shared multiplier,
// which performs 50 products per pixel (gradient products, vertical and
// horizontal blur taps, determinant and trace terms) with a two-stage
// accumulate and write-back tail. After reset the line store is cleared one
// column per cycle, all 1024 columns, with req_stall high; configuration
// writes are taken throughout. A finished result sits in the output register
// while rsp_stall is high. When the next result is ready before that register
// is free, the block holds it in its last step with req_stall high until the
// register can take it. Registers on the csr_ channel are to be written only
// while no pixel is in flight; the block does not enforce it.
module corner_response_stream (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_pixel,
   input  logic req_line_end,
   input  logic req_frame_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [47:0] rsp_response,
   output logic rsp_is_corner,
   output logic rsp_row_done,
   output logic rsp_frame_done,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [crs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crs_pkg::CSR_DATA_W-1:0] csr_data
);
   import crs_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width <= LW_RESET;
         cfg_ff.k_factor <= K_RESET;
         cfg_ff.corner_threshold <= '0;
         cfg_ff.gauss_w[0] <= G0_RESET;
         cfg_ff.gauss_w[1] <= G1_RESET;
         cfg_ff.gauss_w[2] <= G2_RESET;
         cfg_ff.gauss_w[3] <= G3_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: cfg_ff.line_width <= csr_data[LW_W-1:0];
            CSR_K_FACTOR: cfg_ff.k_factor <= csr_data[WGT_W-1:0];
            CSR_THRESHOLD: cfg_ff.corner_threshold <= $signed(csr_data[RSP_W-1:0]);
            CSR_GAUSS_CENTER: cfg_ff.gauss_w[0] <= csr_data[WGT_W-1:0];
            CSR_GAUSS_TAP1: cfg_ff.gauss_w[1] <= csr_data[WGT_W-1:0];
            CSR_GAUSS_TAP2: cfg_ff.gauss_w[2] <= csr_data[WGT_W-1:0];
            CSR_GAUSS_TAP3: cfg_ff.gauss_w[3] <= csr_data[WGT_W-1:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   crs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts(sts),
      .cmd(cmd)
   );

   crs_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .cfg(cfg_ff),
      .req_pixel(req_pixel),
      .req_line_end(req_line_end),
      .req_frame_end(req_frame_end),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_response(rsp_response),
      .rsp_is_corner(rsp_is_corner),
      .rsp_row_done(rsp_row_done),
      .rsp_frame_done(rsp_frame_done)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted twice in a row");

   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open right after reset");

endmodule

/* sim/crs_response_checker.sv */
// Checker for the corner response stream: predicts each response and compares the result beats.
`timescale 1ns / 1ps

module crs_response_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [7:0] req_pixel,
   input  logic req_line_end,
   input  logic req_frame_end,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic signed [47:0] rsp_response,
   input  logic rsp_is_corner,
   input  logic rsp_row_done,
   input  logic rsp_frame_done,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [crs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crs_pkg::CSR_DATA_W-1:0] csr_data,
   output int fail_count,
   output int pending_count,
   output int checked_count
);
   import crs_pkg::*;

   typedef struct {
      logic signed [47:0] response;
      logic is_corner;
      logic row_done;
      logic frame_done;
   } harris_result_type;

   localparam longint R_MAX = (64'sd1 <<< 47) - 1;
   localparam longint R_MIN = -(64'sd1 <<< 47);

   harris_result_type expected_rsp[$];

   logic [10:0] cfg_width;
   longint cfg_k;
   longint cfg_thresh;
   longint cfg_w[4];

   byte unsigned pix_rows[2][MAX_WIDTH];
   int prod_rows[3][GLINES][MAX_WIDTH];
   int unsigned row_idx;
   int unsigned col_idx;
   int win3[3][3];
   longint hwin[3][GWIN];

   function automatic longint rnd16(input longint x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic longint tap_weight(input int d);
      int ad;
      ad = (d < 0) ? -d : d;
      return (ad <= 3) ? cfg_w[ad] : 64'sd0;
   endfunction

   function automatic longint blur_column(input int lane, input int c, input longint cur);
      longint sum;
      sum = 0;
      for (int i = 0; i < GLINES; i++)
         sum += tap_weight(i - 3) * longint'(prod_rows[lane][GLINES-1-i][c]);
      sum += tap_weight(GLINES - 3) * cur;
      for (int i = GLINES - 1; i > 0; i--)
         prod_rows[lane][i][c] = prod_rows[lane][i-1][c];
      prod_rows[lane][0][c] = int'(cur);
      return rnd16(sum);
   endfunction

   function automatic longint blur_row(input int lane, input longint v);
      longint sum;
      sum = 0;
      for (int i = 0; i < GWIN - 1; i++)
         hwin[lane][i] = hwin[lane][i+1];
      hwin[lane][GWIN-1] = v;
      for (int i = 0; i < GWIN; i++)
         sum += tap_weight(i - 3) * hwin[lane][i];
      return rnd16(sum);
   endfunction

   task automatic predict_pixel(input logic [7:0] pix, input logic le, input logic fe);
      int unsigned lw;
      int c;
      int up1, up2, gx, gy;
      longint a, b, cc, tr, t2, kt, r;
      logic line_over, emit;
      harris_result_type res;
      lw = cfg_width;
      if (lw < MIN_WIDTH) lw = MIN_WIDTH;
      if (lw > MAX_WIDTH) lw = MAX_WIDTH;
      c = (col_idx >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_idx;
      up1 = pix_rows[0][c];
      up2 = pix_rows[1][c];
      pix_rows[1][c] = 8'(up1);
      pix_rows[0][c] = pix;
      for (int i = 0; i < 3; i++) begin
         win3[i][0] = win3[i][1];
         win3[i][1] = win3[i][2];
      end
      win3[0][2] = up2;
      win3[1][2] = up1;
      win3[2][2] = pix;
      gx = (win3[0][2] + 2 * win3[1][2] + win3[2][2]) - (win3[0][0] + 2 * win3[1][0] + win3[2][0]);
      gy = (win3[2][0] + 2 * win3[2][1] + win3[2][2]) - (win3[0][0] + 2 * win3[0][1] + win3[0][2]);
      a = blur_row(LANE_XX, blur_column(LANE_XX, c, longint'(gx) * gx));
      b = blur_row(LANE_YY, blur_column(LANE_YY, c, longint'(gy) * gy));
      cc = blur_row(LANE_XY, blur_column(LANE_XY, c, longint'(gx) * gy));
      tr = a + b;
      t2 = tr * tr;
      kt = cfg_k * (t2 >>> 16) + ((cfg_k * (t2 & 64'hFFFF) + 32768) >>> 16);
      r = a * b - cc * cc - kt;
      if (r > R_MAX) r = R_MAX;
      if (r < R_MIN) r = R_MIN;
      emit = (row_idx >= FIRST_OUT) && (col_idx >= FIRST_OUT);
      line_over = le || (col_idx >= lw - 1);
      if (fe) begin
         row_idx = 0;
         col_idx = 0;
      end else if (line_over) begin
         col_idx = 0;
         if (row_idx < 2047) row_idx++;
      end else begin
         col_idx++;
      end
      if (emit) begin
         res.response = r[47:0];
         res.is_corner = r > cfg_thresh;
         res.row_done = line_over;
         res.frame_done = fe;
         expected_rsp.push_back(res);
      end
   endtask

   task automatic check_beat();
      harris_result_type exp_r;
      if (expected_rsp.size() == 0) begin
         $error("result beat with no response expected");
         fail_count++;
         return;
      end
      exp_r = expected_rsp.pop_front();
      checked_count++;
      if (rsp_response !== exp_r.response) begin
         $error("response: expected %0d, got %0d", exp_r.response, rsp_response);
         fail_count++;
      end
      if (rsp_is_corner !== exp_r.is_corner) begin
         $error("is_corner: expected %0b, got %0b", exp_r.is_corner, rsp_is_corner);
         fail_count++;
      end
      if (rsp_row_done !== exp_r.row_done) begin
         $error("row_done: expected %0b, got %0b", exp_r.row_done, rsp_row_done);
         fail_count++;
      end
      if (rsp_frame_done !== exp_r.frame_done) begin
         $error("frame_done: expected %0b, got %0b", exp_r.frame_done, rsp_frame_done);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      checked_count = 0;
   end

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      if (reset) begin
         cfg_width = LW_RESET;
         cfg_k = K_RESET;
         cfg_thresh = 0;
         cfg_w[0] = G0_RESET;
         cfg_w[1] = G1_RESET;
         cfg_w[2] = G2_RESET;
         cfg_w[3] = G3_RESET;
         for (int c = 0; c < MAX_WIDTH; c++) begin
            pix_rows[0][c] = 0;
            pix_rows[1][c] = 0;
            for (int l = 0; l < 3; l++)
               for (int g = 0; g < GLINES; g++)
                  prod_rows[l][g][c] = 0;
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) win3[i][j] = 0;
            for (int j = 0; j < GWIN; j++) hwin[i][j] = 0;
         end
         row_idx = 0;
         col_idx = 0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_WIDTH: cfg_width = csr_data[10:0];
               CSR_K_FACTOR: cfg_k = csr_data[15:0];
               CSR_THRESHOLD: cfg_thresh = longint'(signed'(csr_data[47:0]));
               CSR_GAUSS_CENTER: cfg_w[0] = csr_data[15:0];
               CSR_GAUSS_TAP1: cfg_w[1] = csr_data[15:0];
               CSR_GAUSS_TAP2: cfg_w[2] = csr_data[15:0];
               CSR_GAUSS_TAP3: cfg_w[3] = csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_beat();
         if (req_valid && !req_stall) predict_pixel(req_pixel, req_line_end, req_frame_end);
      end
   end

endmodule

/* sim/tb_corner_response_stream.sv */
// Testbench top for the corner response stream: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb_corner_response_stream;
   import crs_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_pixel;
   logic req_line_end;
   logic req_frame_end;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [47:0] rsp_response;
   logic rsp_is_corner;
   logic rsp_row_done;
   logic rsp_frame_done;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int fail_count;
   int pending_count;
   int checked_count;

   int pixels_sent;
   int frames_sent;
   int settings_used;
   int burst_left;
   int active_width;
   int stall_cycle;
   int stall_mode;

   corner_response_stream u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_pixel(req_pixel),
      .req_line_end(req_line_end), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_response(rsp_response),
      .rsp_is_corner(rsp_is_corner), .rsp_row_done(rsp_row_done),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   crs_response_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_pixel(req_pixel),
      .req_line_end(req_line_end), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_response(rsp_response),
      .rsp_is_corner(rsp_is_corner), .rsp_row_done(rsp_row_done),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("tb_corner_response_stream: errors");
      $finish;
   end

   // The receiver switches between no stalls, light stalls and heavy stalls.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycle <= 0;
         stall_mode <= 0;
         rsp_stall <= 1'b0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 300 == 299) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[47:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_width(input int value);
      write_reg(CSR_LINE_WIDTH, value);
      active_width = (value < MIN_WIDTH) ? MIN_WIDTH : (value > MAX_WIDTH) ? MAX_WIDTH : value;
   endtask

   task automatic set_weights(input int w0, input int w1, input int w2, input int w3);
      write_reg(CSR_GAUSS_CENTER, w0);
      write_reg(CSR_GAUSS_TAP1, w1);
      write_reg(CSR_GAUSS_TAP2, w2);
      write_reg(CSR_GAUSS_TAP3, w3);
      settings_used++;
   endtask

   task automatic send_pixel(input logic [7:0] pix, input logic le, input logic fe);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_line_end <= le;
      req_frame_end <= fe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // Lets the last pixel, which may give no beat, drain before registers change.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic send_frame(input int rows, input int cols, input bit marked, input bit noisy);
      logic [7:0] pix;
      logic le;
      logic fe;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            pix = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
            le = marked && (c == cols - 1);
            fe = (r == rows - 1) && (c == cols - 1);
            if (noisy && $urandom_range(0, 23) == 0) le = ~le;
            if (noisy && $urandom_range(0, 63) == 0) fe = 1'b1;
            send_pixel(pix, le, fe);
         end
      end
      frames_sent++;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      req_line_end = 1'b0;
      req_frame_end = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      pixels_sent = 0;
      frames_sent = 0;
      settings_used = 1;
      burst_left = 0;
      active_width = LW_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a frame end on a border pixel, then a checkerboard frame
      // with marked line ends.
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b1);
      for (int r = 0; r < 10; r++)
         for (int c = 0; c < 11; c++)
            send_pixel(((r + c) % 2) ? 8'd255 : 8'd0, c == 10, (r == 9) && (c == 10));
      frames_sent++;
      wait_idle();

      // Narrowest line (zero is raised to the minimum), strongest weights and k.
      set_width(0);
      write_reg(CSR_K_FACTOR, 65535);
      write_reg(CSR_THRESHOLD, (64'sd1 <<< 47) - 1);
      set_weights(65535, 65535, 65535, 65535);
      send_frame(10, active_width, 1'b0, 1'b0);
      send_frame(11, active_width, 1'b1, 1'b0);
      wait_idle();

      // Widest line (clamped down), zero k, lowest threshold, sparse weights.
      set_width(2047);
      write_reg(CSR_K_FACTOR, 0);
      write_reg(CSR_THRESHOLD, -(64'sd1 <<< 47));
      set_weights(0, 65535, 0, 65535);
      send_frame(10, 12, 1'b1, 1'b0);
      send_frame(9, 10, 1'b1, 1'b1);
      wait_idle();

      while (pixels_sent < 1050) begin
         set_width($urandom_range(0, 5) == 0 ? $urandom_range(0, 2047) : $urandom_range(9, 16));
         write_reg(CSR_K_FACTOR, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                           : $urandom_range(1000, 6000));
         write_reg(CSR_THRESHOLD, $urandom_range(0, 1) ? longint'($urandom) - 64'sd2147483648
                                  : longint'({$urandom, $urandom}) >>> 16);
         if ($urandom_range(0, 2) == 0)
            set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
         else
            set_weights(13037, 11506, 7910, 4232);
         repeat ($urandom_range(1, 2)) begin
            if (active_width <= 16 && $urandom_range(0, 1) == 0)
               send_frame($urandom_range(9, 12), active_width, 1'b0, $urandom_range(0, 4) == 0);
            else
               send_frame($urandom_range(9, 12), $urandom_range(9, 16), 1'b1,
                          $urandom_range(0, 4) == 0);
         end
         wait_idle();
      end

      $display("Sent %0d pixels in %0d frames under %0d weight settings.",
               pixels_sent, frames_sent, settings_used);
      $display("Checked %0d response beats.", checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_corner_response_stream: clean");
      else
         $display("tb_corner_response_stream: errors");
      $finish;
   end

endmodule
